// ===== rtl/core/flv_video_tag_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// FLV video tag deframer assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef FLV_VIDEO_TAG_DEFRAMER_MACROS_SVH
`define FLV_VIDEO_TAG_DEFRAMER_MACROS_SVH

// check under reset release
`define FLVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define FLVD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/flvd_pkg.sv =====
// ----------------------------------------------------------------------------
// FLV deframer package
// Item types, configuration, protocol constants and codes.
// ----------------------------------------------------------------------------
package flvd_pkg;

    localparam int HDR_BYTES        = 13;
    localparam int TAG_HEADER_BYTES = 13;
    localparam int SIZE_BYTES       = 4;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0]  CH_CR           = 8'h0d;
    localparam logic [7:0]  CH_LF           = 8'h0a;
    localparam logic [7:0]  SIG_F           = 8'h46;
    localparam logic [7:0]  SIG_L           = 8'h4c;
    localparam logic [7:0]  SIG_V           = 8'h56;
    localparam logic [7:0]  FLV_VERSION     = 8'h01;
    localparam logic [31:0] FLV_DATA_OFFSET = 32'd9;
    localparam logic [3:0]  CODEC_MASK      = 4'hf;
    localparam logic [1:0]  BLANK_LINES     = 2'd2;

    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic ERR_FLV_HEADER = 1'b0;
    localparam logic ERR_TAG        = 1'b1;

    localparam logic IN_BYTE    = 1'b0;
    localparam logic IN_RESTART = 1'b1;

    localparam logic REG_VIDEO_TAG_TYPE    = 1'b0;
    localparam logic REG_ACCEPTED_CODEC_ID = 1'b1;

    localparam logic [7:0] VIDEO_TAG_TYPE_RESET    = 8'd9;
    localparam logic [3:0] ACCEPTED_CODEC_ID_RESET = 4'd1;

    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [63:0] frame_timestamp;
        logic        last_of_frame;
        logic        error_code;
    } result_t;

    typedef struct packed {
        logic [7:0] video_tag_type;
        logic [3:0] accepted_codec_id;
    } cfg_t;

endpackage

// ===== rtl/core/flvd_regs.sv =====
// ----------------------------------------------------------------------------
// FLV deframer configuration registers
// APB-style register file holding the tag type and codec selections.
// ----------------------------------------------------------------------------
module flvd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [flvd_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [flvd_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [flvd_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output flvd_pkg::cfg_t                   cfg
);
    import flvd_pkg::*;

    logic [7:0] video_tag_type_reg;
    logic [3:0] accepted_codec_id_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_tag_type_reg    <= VIDEO_TAG_TYPE_RESET;
            accepted_codec_id_reg <= ACCEPTED_CODEC_ID_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_VIDEO_TAG_TYPE)
            begin
                video_tag_type_reg <= pwdata[7:0];
            end
            else
            begin
                accepted_codec_id_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_VIDEO_TAG_TYPE)
        begin
            prdata = {{(DATA_WIDTH-8){1'b0}}, video_tag_type_reg};
        end
        else
        begin
            prdata = {{(DATA_WIDTH-4){1'b0}}, accepted_codec_id_reg};
        end
    end

    assign cfg.video_tag_type    = video_tag_type_reg;
    assign cfg.accepted_codec_id = accepted_codec_id_reg;

endmodule

// ===== rtl/core/flvd_parse.sv =====
// ----------------------------------------------------------------------------
// FLV deframer front end
// Tracks the stream phase per byte and produces result requests.
// ----------------------------------------------------------------------------
module flvd_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  flvd_pkg::item_t   item,
    input  flvd_pkg::cfg_t    cfg,
    output logic              res_valid,
    output flvd_pkg::result_t res
);
    import flvd_pkg::*;
    `include "flv_video_tag_deframer_macros.svh"

    localparam logic [2:0] PH_HALT  = 3'd0;
    localparam logic [2:0] PH_REPLY = 3'd1;
    localparam logic [2:0] PH_FLVH  = 3'd2;
    localparam logic [2:0] PH_TAG   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_SIZE  = 3'd5;

    localparam logic [3:0] HDR_LAST  = 4'(HDR_BYTES - 1);
    localparam logic [3:0] TAG_LAST  = 4'(TAG_HEADER_BYTES - 1);
    localparam logic [3:0] SIZE_LAST = 4'(SIZE_BYTES - 1);

    logic [2:0]  phase_reg, phase_next;
    logic        cr_seen_reg, cr_seen_next;
    logic [1:0]  blank_count_reg, blank_count_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [23:0] body_remaining_reg, body_remaining_next;
    logic [63:0] tag_timestamp_reg, tag_timestamp_next;
    logic [7:0]  header_store [HDR_BYTES];
    logic        store_we;

    logic [7:0]  b;
    logic [3:0]  index_inc;
    logic [23:0] body_dec;
    logic [23:0] dsize;
    logic [63:0] ts;
    logic [31:0] offset;
    logic        flv_ok;
    logic        tag_ok;

    assign b         = item.in_byte;
    assign index_inc = byte_index_reg + 4'd1;
    assign body_dec  = body_remaining_reg - 24'd1;
    assign dsize     = {header_store[1], header_store[2], header_store[3]};
    assign ts        = {header_store[4], header_store[5], header_store[6], header_store[7],
                        header_store[8], header_store[9], header_store[10], header_store[11]};
    assign offset    = {header_store[5], header_store[6], header_store[7], header_store[8]};
    assign flv_ok    = (header_store[0] == SIG_F) && (header_store[1] == SIG_L) &&
                       (header_store[2] == SIG_V) && (header_store[3] == FLV_VERSION) &&
                       header_store[4][0] && (offset == FLV_DATA_OFFSET);
    assign tag_ok    = (header_store[0] == cfg.video_tag_type) && (dsize != 24'd0) &&
                       ((b[3:0] & CODEC_MASK) == cfg.accepted_codec_id);

    always_comb
    begin
        phase_next          = phase_reg;
        cr_seen_next        = cr_seen_reg;
        blank_count_next    = blank_count_reg;
        byte_index_next     = byte_index_reg;
        body_remaining_next = body_remaining_reg;
        tag_timestamp_next  = tag_timestamp_reg;
        store_we            = 1'b0;
        res_valid           = 1'b0;
        res                 = '0;
        if (accept)
        begin
            if (item.kind == IN_RESTART)
            begin
                phase_next          = PH_REPLY;
                cr_seen_next        = 1'b0;
                blank_count_next    = 2'd0;
                byte_index_next     = 4'd0;
                body_remaining_next = 24'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_REPLY:
                    begin
                        if (cr_seen_reg && (b == CH_LF))
                        begin
                            blank_count_next = blank_count_reg + 2'd1;
                        end
                        else if (b != CH_CR)
                        begin
                            blank_count_next = 2'd0;
                        end
                        cr_seen_next = (b == CH_CR);
                        if (blank_count_next == BLANK_LINES)
                        begin
                            phase_next      = PH_FLVH;
                            byte_index_next = 4'd0;
                        end
                    end
                    PH_FLVH:
                    begin
                        store_we        = 1'b1;
                        byte_index_next = index_inc;
                        if (byte_index_reg == HDR_LAST)
                        begin
                            if (!flv_ok)
                            begin
                                phase_next     = PH_HALT;
                                res_valid      = 1'b1;
                                res.out_kind   = KIND_ERROR;
                                res.error_code = ERR_FLV_HEADER;
                            end
                            else
                            begin
                                phase_next      = PH_TAG;
                                byte_index_next = 4'd0;
                            end
                        end
                    end
                    PH_TAG:
                    begin
                        store_we        = 1'b1;
                        byte_index_next = index_inc;
                        if (byte_index_reg == TAG_LAST)
                        begin
                            if (!tag_ok)
                            begin
                                phase_next     = PH_HALT;
                                res_valid      = 1'b1;
                                res.out_kind   = KIND_ERROR;
                                res.error_code = ERR_TAG;
                            end
                            else
                            begin
                                tag_timestamp_next  = ts;
                                body_remaining_next = dsize - 24'd1;
                                if (dsize == 24'd1)
                                begin
                                    phase_next          = PH_SIZE;
                                    byte_index_next     = 4'd0;
                                    res_valid           = 1'b1;
                                    res.out_kind        = KIND_EMPTY;
                                    res.frame_timestamp = ts;
                                    res.last_of_frame   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        body_remaining_next = body_dec;
                        res_valid           = 1'b1;
                        res.out_kind        = KIND_BODY;
                        res.out_byte        = b;
                        res.frame_timestamp = tag_timestamp_reg;
                        res.last_of_frame   = (body_dec == 24'd0);
                        if (body_dec == 24'd0)
                        begin
                            phase_next      = PH_SIZE;
                            byte_index_next = 4'd0;
                        end
                    end
                    PH_SIZE:
                    begin
                        byte_index_next = index_inc;
                        if (byte_index_reg >= SIZE_LAST)
                        begin
                            phase_next      = PH_TAG;
                            byte_index_next = 4'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HALT;
            cr_seen_reg        <= 1'b0;
            blank_count_reg    <= 2'd0;
            byte_index_reg     <= 4'd0;
            body_remaining_reg <= 24'd0;
            tag_timestamp_reg  <= 64'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            cr_seen_reg        <= cr_seen_next;
            blank_count_reg    <= blank_count_next;
            byte_index_reg     <= byte_index_next;
            body_remaining_reg <= body_remaining_next;
            tag_timestamp_reg  <= tag_timestamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            header_store[byte_index_reg] <= b;
        end
    end

    `FLVD_ASSERT(a_error_halts, (res_valid && (res.out_kind == KIND_ERROR)) |=> (phase_reg == PH_HALT), "error request did not halt the parser")
    `FLVD_ASSERT(a_restart_enters_reply, (accept && (item.kind == IN_RESTART)) |=> ((phase_reg == PH_REPLY) && (body_remaining_reg == 24'd0)), "restart did not enter reply skipping")

endmodule

// ===== rtl/core/flvd_queue.sv =====
// ----------------------------------------------------------------------------
// FLV deframer result queue
// Short FIFO that decouples the parser from the result consumer.
// ----------------------------------------------------------------------------
module flvd_queue #(
    parameter int DEPTH = flvd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  flvd_pkg::result_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output flvd_pkg::result_t rd_data,
    output logic              empty
);
    import flvd_pkg::*;
    `include "flv_video_tag_deframer_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `FLVD_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_FULL, "queue count exceeds depth")
    `FLVD_ASSERT(a_count_tracks, (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "queue count missed a write")

endmodule

// ===== rtl/core/flv_video_tag_deframer.sv =====
// ----------------------------------------------------------------------------
// FLV video tag deframer
// Skips an HTTP reply, checks the FLV header and passes video tag bodies out.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  item     | push / full          | kind, in_byte
//  result   | pop / empty          | out_kind, out_byte, frame_timestamp,
//           |                      | last_of_frame, error_code
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
//  One item per cycle while full is low; each byte is a single phase update in the parser.
//  A result enters the queue at the edge its item is accepted and can be
//  popped from the next cycle on.
//  full rises when the QUEUE_DEPTH-entry result queue is full; the parser
//  then holds until the consumer pops.
//  Reset leaves the parser halted until a restart item arrives.
// ----------------------------------------------------------------------------
module flv_video_tag_deframer #(
    parameter int QUEUE_DEPTH = flvd_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  flvd_pkg::item_t                  item,
    output logic                             empty,
    input  logic                             pop,
    output flvd_pkg::result_t                result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [flvd_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [flvd_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [flvd_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready
);
    import flvd_pkg::*;

    cfg_t    cfg;
    logic    accept;
    logic    res_valid;
    result_t res;

    assign accept = push && !full;

    flvd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flvd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    flvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== bench/tb_flv_video_tag_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV video tag deframer testbench
// Feeds HTTP replies, FLV headers and video tags with random content, broken
// headers and tags, and restarts in mid-stream, under several register
// settings and with random gaps on both queue sides. Every result popped is
// compared in order against an internal prediction of the parser.
// ----------------------------------------------------------------------------
module tb_flv_video_tag_deframer;
    import flvd_pkg::*;

    typedef enum logic [2:0] {
        ST_HALT,
        ST_REPLY,
        ST_FLVH,
        ST_TAG,
        ST_BODY,
        ST_SIZE
    } parse_state_e;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 16;
    localparam int PHASE_ITEMS     = 120;

    localparam logic [ADDR_WIDTH-1:0] ADDR_TAG_TYPE = {REG_VIDEO_TAG_TYPE, 2'b00};
    localparam logic [ADDR_WIDTH-1:0] ADDR_CODEC    = {REG_ACCEPTED_CODEC_ID, 2'b00};

    class FlvFrameChecker;
        logic [7:0]   tag_type_cfg;
        logic [3:0]   codec_cfg;
        parse_state_e state;
        logic         cr_flag;
        logic [1:0]   line_ends;
        logic [3:0]   idx;
        logic [7:0]   hdr [HDR_BYTES];
        logic [23:0]  body_left;
        logic [63:0]  ts_hold;
        result_t      frames_due [$];
        int           errors;

        function new();
            tag_type_cfg = VIDEO_TAG_TYPE_RESET;
            codec_cfg    = ACCEPTED_CODEC_ID_RESET;
            state        = ST_HALT;
            cr_flag      = 1'b0;
            line_ends    = '0;
            idx          = '0;
            foreach (hdr[i])
                hdr[i] = '0;
            body_left    = '0;
            ts_hold      = '0;
            errors       = 0;
        endfunction

        function void write_cfg(logic [ADDR_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
            if (addr == ADDR_TAG_TYPE)
                tag_type_cfg = data[7:0];
            else if (addr == ADDR_CODEC)
                codec_cfg = data[3:0];
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void add_frame(logic [1:0] kind, logic [7:0] data, logic [63:0] ts,
                                logic last, logic code);
            result_t r;
            r.out_kind        = kind;
            r.out_byte        = data;
            r.frame_timestamp = ts;
            r.last_of_frame   = last;
            r.error_code      = code;
            frames_due.push_back(r);
        endfunction

        function void note_request(item_t req);
            logic [7:0]  b;
            logic [23:0] dsize;
            b = req.in_byte;
            if (req.kind == IN_RESTART)
            begin
                state     = ST_REPLY;
                cr_flag   = 1'b0;
                line_ends = '0;
                idx       = '0;
                body_left = '0;
                return;
            end
            case (state)
                ST_REPLY:
                begin
                    if (cr_flag && b == CH_LF)
                        line_ends = line_ends + 2'd1;
                    else if (b != CH_CR)
                        line_ends = '0;
                    cr_flag = (b == CH_CR);
                    if (line_ends == BLANK_LINES)
                    begin
                        state = ST_FLVH;
                        idx   = '0;
                    end
                end
                ST_FLVH:
                begin
                    hdr[idx % HDR_BYTES] = b;
                    idx = idx + 4'd1;
                    if (idx >= HDR_BYTES)
                    begin
                        if (hdr[0] == SIG_F && hdr[1] == SIG_L && hdr[2] == SIG_V &&
                            hdr[3] == FLV_VERSION && hdr[4][0] &&
                            {hdr[5], hdr[6], hdr[7], hdr[8]} == FLV_DATA_OFFSET)
                        begin
                            state = ST_TAG;
                            idx   = '0;
                        end
                        else
                        begin
                            state = ST_HALT;
                            add_frame(KIND_ERROR, 8'h00, 64'h0, 1'b0, ERR_FLV_HEADER);
                        end
                    end
                end
                ST_TAG:
                begin
                    hdr[idx % TAG_HEADER_BYTES] = b;
                    idx = idx + 4'd1;
                    if (idx >= TAG_HEADER_BYTES)
                    begin
                        dsize = {hdr[1], hdr[2], hdr[3]};
                        if (hdr[0] != tag_type_cfg || dsize == 24'd0 ||
                            (hdr[12][3:0] & CODEC_MASK) != codec_cfg)
                        begin
                            state = ST_HALT;
                            add_frame(KIND_ERROR, 8'h00, 64'h0, 1'b0, ERR_TAG);
                        end
                        else
                        begin
                            ts_hold = {hdr[4], hdr[5], hdr[6], hdr[7],
                                       hdr[8], hdr[9], hdr[10], hdr[11]};
                            body_left = dsize - 24'd1;
                            if (body_left == 24'd0)
                            begin
                                state = ST_SIZE;
                                idx   = '0;
                                add_frame(KIND_EMPTY, 8'h00, ts_hold, 1'b1, 1'b0);
                            end
                            else
                                state = ST_BODY;
                        end
                    end
                end
                ST_BODY:
                begin
                    body_left = body_left - 24'd1;
                    if (body_left == 24'd0)
                    begin
                        state = ST_SIZE;
                        idx   = '0;
                        add_frame(KIND_BODY, b, ts_hold, 1'b1, 1'b0);
                    end
                    else
                        add_frame(KIND_BODY, b, ts_hold, 1'b0, 1'b0);
                end
                ST_SIZE:
                begin
                    idx = idx + 4'd1;
                    if (idx >= SIZE_BYTES)
                    begin
                        state = ST_TAG;
                        idx   = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (frames_due.size() == 0)
            begin
                $error("result with no request pending: out_kind %0d", got.out_kind);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.out_kind !== want.out_kind)
            begin
                $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
                errors++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.frame_timestamp !== want.frame_timestamp)
            begin
                $error("frame_timestamp: expected %h, actual %h",
                       want.frame_timestamp, got.frame_timestamp);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame)
            begin
                $error("last_of_frame: expected %0d, actual %0d",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    item_t                 item;
    logic                  empty;
    logic                  pop = 1'b0;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    FlvFrameChecker frames;
    int             send_idle_pct = 0;
    int             pop_stall_pct = 0;
    int             items_sent = 0;
    int             quiet_cycles = 0;

    always #2 clk = ~clk;

    flv_video_tag_deframer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (pop && !empty)
                frames.check_result(result);
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_CYCLES)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        item_t req;
        req.kind    = kind;
        req.in_byte = data;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            item <= item_t'(9'($urandom));
            @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        frames.note_request(req);
        items_sent++;
    endtask

    task automatic write_reg(input logic [ADDR_WIDTH-1:0] addr,
                             input logic [DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        frames.write_cfg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain(input int extra);
        push <= 1'b0;
        while (frames.pending() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    function automatic logic [7:0] reply_char();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == CH_CR)
            c = 8'h20;
        return c;
    endfunction

    task automatic run_directed();
        // halted after reset: no result
        send_item(IN_BYTE, 8'h00);
        send_item(IN_BYTE, 8'hff);
        send_item(IN_RESTART, 8'hff);
        // line end, cleared by text, then CR alone keeping the count
        send_item(IN_BYTE, CH_CR);
        send_item(IN_BYTE, CH_LF);
        send_item(IN_BYTE, 8'h41);
        send_item(IN_BYTE, CH_CR);
        send_item(IN_BYTE, CH_CR);
        send_item(IN_BYTE, CH_LF);
        send_item(IN_BYTE, CH_CR);
        send_item(IN_BYTE, CH_LF);
        // FLV header with the video flag clear
        send_item(IN_BYTE, SIG_F);
        send_item(IN_BYTE, SIG_L);
        send_item(IN_BYTE, SIG_V);
        send_item(IN_BYTE, FLV_VERSION);
        send_item(IN_BYTE, 8'hfe);
        send_item(IN_BYTE, FLV_DATA_OFFSET[31:24]);
        send_item(IN_BYTE, FLV_DATA_OFFSET[23:16]);
        send_item(IN_BYTE, FLV_DATA_OFFSET[15:8]);
        send_item(IN_BYTE, FLV_DATA_OFFSET[7:0]);
        send_item(IN_BYTE, 8'h00);
        send_item(IN_BYTE, 8'hff);
        send_item(IN_BYTE, 8'h00);
        send_item(IN_BYTE, 8'hff);
    endtask

    task automatic run_session();
        logic [7:0]  flv_hdr [HDR_BYTES];
        logic [7:0]  tag [TAG_HEADER_BYTES];
        logic [23:0] dsize;
        logic [63:0] ts;
        int          lines;
        int          pick;
        int          ntags;
        int          body_len;
        bit          cut;
        send_item(IN_RESTART, 8'($urandom));
        if ($urandom_range(0, 9) == 0)
        begin
            // noise dense in CR and LF
            repeat ($urandom_range(4, 24))
            begin
                pick = $urandom_range(0, 3);
                send_item(IN_BYTE, pick == 0 ? CH_CR : pick == 1 ? CH_LF : 8'($urandom));
            end
            return;
        end

        lines = $urandom_range(0, 3);
        if (lines == 0)
        begin
            send_item(IN_BYTE, CH_CR);
            send_item(IN_BYTE, CH_LF);
        end
        repeat (lines)
        begin
            repeat ($urandom_range(1, 6))
                send_item(IN_BYTE, reply_char());
            if ($urandom_range(0, 3) == 0)
                send_item(IN_BYTE, CH_CR);
            send_item(IN_BYTE, CH_CR);
            send_item(IN_BYTE, CH_LF);
        end
        send_item(IN_BYTE, CH_CR);
        send_item(IN_BYTE, CH_LF);

        flv_hdr[0] = SIG_F;
        flv_hdr[1] = SIG_L;
        flv_hdr[2] = SIG_V;
        flv_hdr[3] = FLV_VERSION;
        flv_hdr[4] = 8'($urandom) | 8'h01;
        flv_hdr[5] = FLV_DATA_OFFSET[31:24];
        flv_hdr[6] = FLV_DATA_OFFSET[23:16];
        flv_hdr[7] = FLV_DATA_OFFSET[15:8];
        flv_hdr[8] = FLV_DATA_OFFSET[7:0];
        for (int k = 9; k < HDR_BYTES; k++)
            flv_hdr[k] = 8'($urandom);
        cut = ($urandom_range(0, 7) == 0);
        if (cut)
        begin
            pick = $urandom_range(0, 8);
            if (pick == 4)
                flv_hdr[4][0] = 1'b0;
            else
                flv_hdr[pick] = flv_hdr[pick] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < HDR_BYTES; k++)
            send_item(IN_BYTE, flv_hdr[k]);
        if (cut)
        begin
            repeat ($urandom_range(0, 3))
                send_item(IN_BYTE, 8'($urandom));
            return;
        end

        ntags = $urandom_range(1, 5);
        repeat (ntags)
        begin
            pick  = $urandom_range(0, 15);
            dsize = 24'($urandom_range(2, 7));
            if (pick == 0)
                dsize = 24'd0;
            else if (pick <= 2)
                dsize = 24'd1;
            else if (pick == 3)
                dsize = 24'($urandom_range(20, 40));
            else if (pick == 4)
                dsize = 24'hffffff - 24'($urandom_range(0, 255));
            ts = {$urandom, $urandom};
            if (pick == 5)
                ts = '1;
            else if (pick == 6)
                ts = '0;
            tag[0] = frames.tag_type_cfg;
            if (pick == 7)
                tag[0] = tag[0] ^ 8'($urandom_range(1, 255));
            tag[1] = dsize[23:16];
            tag[2] = dsize[15:8];
            tag[3] = dsize[7:0];
            for (int k = 0; k < 8; k++)
                tag[4 + k] = ts[63 - 8 * k -: 8];
            tag[12] = {4'($urandom), frames.codec_cfg};
            if (pick == 8)
                tag[12][3:0] = tag[12][3:0] ^ 4'($urandom_range(1, 15));
            for (int k = 0; k < TAG_HEADER_BYTES; k++)
                send_item(IN_BYTE, tag[k]);
            if (pick == 0 || pick == 7 || pick == 8)
            begin
                repeat ($urandom_range(0, 3))
                    send_item(IN_BYTE, 8'($urandom));
                return;
            end
            body_len = int'(dsize) - 1;
            cut = (pick == 4) || ($urandom_range(0, 24) == 0);
            if (cut)
                body_len = $urandom_range(0, body_len < 6 ? body_len : 6);
            repeat (body_len)
                send_item(IN_BYTE, 8'($urandom));
            // drop the frame by restarting, in mid-body unless the whole body went out
            if (cut)
                return;
            repeat (SIZE_BYTES)
                send_item(IN_BYTE, 8'($urandom));
        end
    endtask

    task automatic run_phase(input logic [7:0] tag_type, input logic [3:0] codec,
                             input int idle_pct, input int stall_pct, input int target);
        drain(SETTLE_CYCLES);
        write_reg(ADDR_TAG_TYPE, {24'($urandom), tag_type});
        write_reg(ADDR_CODEC, {28'($urandom), codec});
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        while (items_sent < target)
            run_session();
    endtask

    initial
    begin
        frames  = new();
        rst_n   <= 1'b0;
        push    <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        while (items_sent < PHASE_ITEMS)
            run_session();
        run_phase(8'h00, 4'h0, 86, 0, 2 * PHASE_ITEMS);
        run_phase(8'hff, 4'hf, 0, 86, 3 * PHASE_ITEMS);
        run_phase(8'($urandom), 4'($urandom), 37, 37, 4 * PHASE_ITEMS);
        run_phase(VIDEO_TAG_TYPE_RESET, ACCEPTED_CODEC_ID_RESET, 0, 0, 5 * PHASE_ITEMS);

        drain(DRAIN_CYCLES);
        if (frames.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/flvd_pkg.sv
rtl/core/flvd_regs.sv
rtl/core/flvd_parse.sv
rtl/core/flvd_queue.sv
rtl/core/flv_video_tag_deframer.sv
bench/tb_flv_video_tag_deframer.sv
